// File: design/rgbhsv_pkg.sv
// Package for the RGB to HSV converter: widths, constants and the cell payload type.
// Used by every module of the converter; depends on nothing.
package rgbhsv_pkg;

    localparam int HUE_FRAC_BITS = 6;
    localparam int SAT_BITS      = 16;
    localparam int HUE_W         = 15;
    localparam int SAT_W         = 16;
    localparam int CH_W          = 8;
    // Both quotients are computed as unsigned fractions of up to 17 bits.
    localparam int Q_W           = 17;
    // Numerator width: 255 * 3840 or 255 * 65535 fits in 24 bits.
    localparam int NUM_W         = 24;
    localparam int DEN_W         = 8;

    localparam logic [NUM_W-1:0] HUE_SCALE = NUM_W'(60 * (1 << HUE_FRAC_BITS));
    localparam logic [NUM_W-1:0] SAT_SCALE = NUM_W'((1 << SAT_BITS) - 1);
    localparam logic [HUE_W:0]   HUE_FULL  = (HUE_W+1)'(360 * (1 << HUE_FRAC_BITS));
    localparam logic [HUE_W:0]   HUE_U     = (HUE_W+1)'(1 << HUE_FRAC_BITS);

    typedef enum logic [2:0]
    {
        SEG_RED   = 3'b001,
        SEG_GREEN = 3'b010,
        SEG_BLUE  = 3'b100
    } seg_t;

    // Everything one pipeline cell carries for one pixel.
    typedef struct packed
    {
        logic             vld;
        logic [NUM_W-1:0] hue_rem;
        logic [NUM_W-1:0] sat_rem;
        logic [DEN_W-1:0] delta;
        logic [DEN_W-1:0] hi;
        logic [Q_W-1:0]   hue_q;
        logic [Q_W-1:0]   sat_q;
        logic             neg;
        logic             grey;
        seg_t             seg;
    } cell_t;

endpackage

// File: design/rgb_to_hsv_converter_top.sv
// Top level of the RGB to HSV converter: front cell, division cells, output stage.
// Depends on rgbhsv_pkg, rgbhsv_front and rgbhsv_div_cell.
//
// The converter takes one 24-bit pixel per clock and returns hue (1/64 degree,
// 0..23039), saturation (scaled by 65535, truncated) and value (the largest
// channel byte). Each request passes a front cell that finds the largest and
// smallest channels, then a row of seventeen identical division cells that each
// settle one quotient bit of both the hue fraction and the saturation, and then
// an output register that applies the sector offset and the wrap. Throughput
// is one pixel per clock while the output is not held. The whole row advances
// together, so when the output is held by a low ready the row stalls and
// ready falls until the result is taken. Grey pixels give hue 0 and black
// pixels give saturation 0.
module rgb_to_hsv_converter_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [23:0] pixel,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [14:0] hue,
    output logic [15:0] saturation,
    output logic [7:0]  brightness
);
    import rgbhsv_pkg::*;

    cell_t          chain [Q_W+1];
    logic           en;
    logic           out_valid_reg;
    logic [HUE_W-1:0] hue_reg, hue_next;
    logic [SAT_W-1:0] sat_reg;
    logic [CH_W-1:0]  bri_reg;
    logic [HUE_W:0]   base, frac, sum;
    cell_t            last;

    // The row moves whenever the output register is empty or being emptied.
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    rgbhsv_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (in_valid),
        .pixel    (pixel),
        .cell_out (chain[0])
    );

    // Cell k resolves quotient bit Q_W-1-k, most significant first.
    for (genvar k = 0; k < Q_W; k++)
    begin : g_cell
        rgbhsv_div_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .bit_pos  (5'(Q_W - 1 - k)),
            .cell_in  (chain[k]),
            .cell_out (chain[k+1])
        );
    end

    assign last = chain[Q_W];

    // Floor division of a negative difference: negate and round the magnitude up.
    always_comb
    begin
        unique case (last.seg)
            SEG_RED:   base = '0;
            SEG_GREEN: base = (HUE_W+1)'(120) * HUE_U;
            SEG_BLUE:  base = (HUE_W+1)'(240) * HUE_U;
            default:   base = '0;
        endcase
        frac = (HUE_W+1)'(last.hue_q) + (HUE_W+1)'(last.neg && last.hue_rem != '0);
        if (last.neg)
        begin
            sum = base - frac;
            if (frac > base)
            begin
                sum = sum + HUE_FULL;
            end
        end
        else
        begin
            sum = base + frac;
        end
        hue_next = last.grey ? '0 : sum[HUE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= last.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue_reg <= hue_next;
            sat_reg <= last.sat_q[SAT_W-1:0];
            bri_reg <= last.hi;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign brightness = bri_reg;

endmodule

// File: design/rgbhsv_front.sv
// Front cell: splits the pixel, finds max, min, branch and the two numerators.
// Depends on rgbhsv_pkg.
module rgbhsv_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_vld,
    input  logic [23:0]                   pixel,
    output rgbhsv_pkg::cell_t             cell_out
);
    import rgbhsv_pkg::*;

    logic [CH_W-1:0] red, grn, blu, hi, lo, dlt;
    logic [CH_W:0]   diff;
    logic            neg;
    logic [CH_W-1:0] mag;
    seg_t            seg;
    cell_t           cell_reg, cell_next;

    always_comb
    begin
        red = pixel[23:16];
        grn = pixel[15:8];
        blu = pixel[7:0];
        hi  = (red > grn) ? red : grn;
        lo  = (red < grn) ? red : grn;
        hi  = (hi > blu) ? hi : blu;
        lo  = (lo < blu) ? lo : blu;
        dlt = hi - lo;
        if (hi == red)
        begin
            seg  = SEG_RED;
            diff = {1'b0, grn} - {1'b0, blu};
        end
        else if (hi == grn)
        begin
            seg  = SEG_GREEN;
            diff = {1'b0, blu} - {1'b0, red};
        end
        else
        begin
            seg  = SEG_BLUE;
            diff = {1'b0, red} - {1'b0, grn};
        end
        neg = diff[CH_W];
        mag = neg ? CH_W'(-diff) : diff[CH_W-1:0];

        cell_next.vld     = in_vld;
        cell_next.hue_rem = NUM_W'({16'd0, mag} * HUE_SCALE);
        cell_next.sat_rem = NUM_W'({16'd0, dlt} * SAT_SCALE);
        cell_next.delta   = dlt;
        cell_next.hi      = hi;
        cell_next.hue_q   = '0;
        cell_next.sat_q   = '0;
        cell_next.neg     = neg;
        cell_next.grey    = (dlt == '0);
        cell_next.seg     = seg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

// File: design/rgbhsv_div_cell.sv
// One restoring-division cell: resolves one quotient bit of hue and saturation.
// Depends on rgbhsv_pkg.
module rgbhsv_div_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic [4:0]                    bit_pos,
    input  rgbhsv_pkg::cell_t             cell_in,
    output rgbhsv_pkg::cell_t             cell_out
);
    import rgbhsv_pkg::*;

    logic [NUM_W+Q_W-1:0] hue_trial, sat_trial;
    cell_t                cell_reg, cell_next;

    always_comb
    begin
        cell_next = cell_in;
        hue_trial = (NUM_W+Q_W)'(cell_in.delta) << bit_pos;
        sat_trial = (NUM_W+Q_W)'(cell_in.hi) << bit_pos;
        if (cell_in.delta != '0 && (NUM_W+Q_W)'(cell_in.hue_rem) >= hue_trial)
        begin
            cell_next.hue_rem = NUM_W'((NUM_W+Q_W)'(cell_in.hue_rem) - hue_trial);
            cell_next.hue_q   = cell_in.hue_q | (Q_W'(1) << bit_pos);
        end
        if (cell_in.hi != '0 && (NUM_W+Q_W)'(cell_in.sat_rem) >= sat_trial)
        begin
            cell_next.sat_rem = NUM_W'((NUM_W+Q_W)'(cell_in.sat_rem) - sat_trial);
            cell_next.sat_q   = cell_in.sat_q | (Q_W'(1) << bit_pos);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

// File: tb/rgb_to_hsv_converter_top_test.sv
// Self-checking testbench for the RGB to HSV converter top level.
// Depends on rgbhsv_pkg and the rgb_to_hsv_converter_top RTL; reads no files.
`timescale 1ns / 100ps

// Holds the expected hue, saturation and value of every pixel that the
// converter has accepted, oldest first, and compares each result with them.
class hsv_scoreboard;

    typedef struct
    {
        logic [23:0] pixel;
        logic [14:0] hue;
        logic [15:0] sat;
        logic [7:0]  val;
    } hsv_expect_t;

    hsv_expect_t pending_hsv[$];
    int          mismatches;
    int          results_seen;

    function new();
        mismatches   = 0;
        results_seen = 0;
    endfunction

    // Works out hue, saturation and value for one pixel in plain integers.
    function hsv_expect_t convert(logic [23:0] pix);
        hsv_expect_t e;
        int r;
        int g;
        int b;
        int hi;
        int lo;
        int delta;
        int offset;
        int diff;
        int num;
        int q;
        int h;
        r  = int'(pix[23:16]);
        g  = int'(pix[15:8]);
        b  = int'(pix[7:0]);
        hi = (r > g) ? r : g;
        lo = (r < g) ? r : g;
        hi = (hi > b) ? hi : b;
        lo = (lo < b) ? lo : b;
        delta = hi - lo;
        h = 0;
        if (delta != 0)
        begin
            if (hi == r)
            begin
                offset = 0;
                diff   = g - b;
            end
            else if (hi == g)
            begin
                offset = 120;
                diff   = b - r;
            end
            else
            begin
                offset = 240;
                diff   = r - g;
            end
            num = 60 * (1 << rgbhsv_pkg::HUE_FRAC_BITS) * diff;
            // Floor division towards minus infinity.
            if (num >= 0)
                q = num / delta;
            else
                q = -((-num + delta - 1) / delta);
            h = offset * (1 << rgbhsv_pkg::HUE_FRAC_BITS) + q;
            if (h < 0)
                h = h + 360 * (1 << rgbhsv_pkg::HUE_FRAC_BITS);
        end
        e.pixel = pix;
        e.hue   = 15'(h);
        e.sat   = (hi != 0) ? 16'((delta * ((1 << rgbhsv_pkg::SAT_BITS) - 1)) / hi) : 16'd0;
        e.val   = 8'(hi);
        return e;
    endfunction

    function void note_request(logic [23:0] pix);
        pending_hsv.insert(pending_hsv.size(), convert(pix));
    endfunction

    task report_mismatch(string what);
        mismatches++;
        $display("ERROR %0t: %s", $realtime, what);
    endtask

    task check_result(logic [14:0] h, logic [15:0] s, logic [7:0] v);
        hsv_expect_t e;
        results_seen++;
        if (pending_hsv.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result hue %0d sat %0d val %0d", h, s, v));
        end
        else
        begin
            e = pending_hsv.pop_front();
            if (h !== e.hue)
                report_mismatch($sformatf("pixel %06h hue %0d, want %0d", e.pixel, h, e.hue));
            if (s !== e.sat)
                report_mismatch($sformatf("pixel %06h sat %0d, want %0d", e.pixel, s, e.sat));
            if (v !== e.val)
                report_mismatch($sformatf("pixel %06h val %0d, want %0d", e.pixel, v, e.val));
        end
    endtask

endclass

module rgb_to_hsv_converter_top_test;

    import rgbhsv_pkg::*;

    localparam int LATENCY      = 19;
    // Cycles without any accepted request or result before the run is
    // declared hung; well above the longest deliberate stall below.
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_COUNT = 400;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [23:0] pixel;
    logic        out_valid;
    logic        out_ready;
    logic [14:0] hue;
    logic [15:0] saturation;
    logic [7:0]  brightness;

    hsv_scoreboard scoreboard;

    // Control between the sender and the receiver processes.
    bit quiet_phase;     // no idling on either side once set
    bit hold_receiver;   // request for one long receiver stall
    bit stimulus_done;
    int requests_sent;

    rgb_to_hsv_converter_top u_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel      (pixel),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #10 clk = ~clk;
    end

    initial
    begin
        scoreboard    = new();
        quiet_phase   = 1'b0;
        hold_receiver = 1'b0;
        stimulus_done = 1'b0;
        requests_sent = 0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        pixel         = 24'd0;
        out_ready     = 1'b0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
    end

    // Sends one pixel and holds it until the converter accepts it. The valid
    // is not lowered here, only by a gap, a drain or the end of the run, so a
    // back-to-back request keeps it high without a second assignment in the same time step.
    task send_pixel(logic [23:0] pix);
        in_valid <= 1'b1;
        pixel    <= pix;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // The request is accepted at this edge; note it for the scoreboard.
        scoreboard.note_request(pix);
        requests_sent++;
    endtask

    task sender_gap();
        int gap;
        if (!quiet_phase && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 14);
            repeat (gap)
                @(posedge clk);
        end
    endtask

    task wait_drained();
        in_valid <= 1'b0;
        while (scoreboard.pending_hsv.size() != 0)
            @(posedge clk);
    endtask

    // Random pixel: mostly any colour, with some grey, black, saturated and
    // tie-heavy pixels so that every branch of the hue selection is busy.
    function logic [23:0] random_pixel();
        logic [7:0] a;
        logic [7:0] b;
        a = 8'($urandom);
        b = 8'($urandom);
        case ($urandom_range(0, 9))
            0: return {a, a, a};
            1: return {a, a, b};
            2: return {a, b, a};
            3: return {b, a, a};
            4: return {8'hff, a, 8'h00};
            5: return {8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                       8'($urandom_range(0, 3))};
            default: return 24'($urandom);
        endcase
    endfunction

    // Sender: a directed opening, then random pixels with random gaps.
    initial
    begin
        logic [23:0] directed_px[$];
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        @(posedge clk);

        // Black, white, grey, each primary and secondary, ties between the
        // largest channels, the wrap of a negative red hue, and near-grey.
        directed_px = '{24'h000000, 24'hffffff, 24'h808080, 24'hff0000,
                        24'h00ff00, 24'h0000ff, 24'hffff00, 24'h00ffff,
                        24'hff00ff, 24'hff0001, 24'hfe00ff, 24'h01ff00,
                        24'h0100ff, 24'h010000, 24'h000100, 24'h000001,
                        24'hfffffe, 24'h7f7f80, 24'haa5555, 24'h55aa55,
                        24'h5555aa, 24'h123456, 24'hfedcba, 24'h0f0f0e};
        foreach (directed_px[i])
            send_pixel(directed_px[i]);

        // Pause until every expected result has come.
        wait_drained();

        // Random part; a long receiver stall is requested part way through
        // while pixels keep coming, so the pipeline fills and in_ready falls.
        for (int n = 0; n < RANDOM_COUNT; n++)
        begin
            if (n == 100)
                hold_receiver = 1'b1;
            if (n == 300)
                quiet_phase = 1'b1;
            send_pixel(random_pixel());
            if (!quiet_phase)
                sender_gap();
        end
        in_valid      <= 1'b0;
        stimulus_done = 1'b1;
    end

    // Receiver: random stalls, one long hold-off when asked, none at the end.
    initial
    begin
        int stall;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_receiver)
            begin
                hold_receiver = 1'b0;
                out_ready <= 1'b0;
                repeat (LATENCY * 4)
                    @(posedge clk);
            end
            else if (!quiet_phase && $urandom_range(0, 4) == 0)
            begin
                stall = $urandom_range(1, 14);
                out_ready <= 1'b0;
                repeat (stall)
                    @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Output monitor: sampled at the edge, after the previous drive settled.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            scoreboard.check_result(hue, saturation, brightness);
    end

    // Watchdog and end of run.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
                $display("rgb_to_hsv_converter_top: mismatch");
                $finish;
            end
            if (stimulus_done && scoreboard.pending_hsv.size() == 0)
            begin
                // Let any stray result show itself before the verdict.
                repeat (LATENCY + 5)
                    @(posedge clk);
                $display("Covered %0d pixels (directed extremes, ties, grey, black, random),",
                         requests_sent);
                $display("%0d results checked with random stalls on both sides.",
                         scoreboard.results_seen);
                if (scoreboard.mismatches == 0 && scoreboard.pending_hsv.size() == 0)
                    $display("rgb_to_hsv_converter_top: match");
                else
                    $display("rgb_to_hsv_converter_top: mismatch");
                $finish;
            end
        end
    end

endmodule
